// ===== rtl/pts_pkg.sv =====
package pts_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int RES_LIMIT  = 16;
  localparam int SLOT_W     = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int FCNT_W     = $clog2(RES_LIMIT + 1);

  localparam logic [1:0] REQ_SUBMIT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] EV_SUBMIT  = 2'd0;
  localparam logic [1:0] EV_REMOVE  = 2'd1;
  localparam logic [1:0] EV_FIRE    = 2'd2;

  typedef struct packed {
    logic              load;
    logic              time_inc;
    logic              do_submit;
    logic              do_remove;
    logic              pend_load;
    logic              scan_step;
    logic              scan_first;
    logic [SLOT_W-1:0] scan_idx;
    logic              fire;
  } pts_cmd_t;

  typedef struct packed {
    logic none_pending;
    logic fire_last;
  } pts_sts_t;

endpackage

// ===== rtl/pts_ctrl.sv =====
module pts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [1:0]       req_type_i,
  output logic             busy,
  input  pts_pkg::pts_sts_t sts_i,
  output pts_pkg::pts_cmd_t cmd_o
);
  import pts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUBMIT,
    ST_REMOVE,
    ST_PEND,
    ST_SCAN,
    ST_FIRE
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    cmd_o          = '0;
    cmd_o.scan_idx = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (req_type_i)
            REQ_SUBMIT: state_d = ST_SUBMIT;
            REQ_REMOVE: state_d = ST_REMOVE;
            REQ_TICK: begin
              cmd_o.time_inc = 1'b1;
              state_d        = ST_PEND;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SUBMIT: begin
        cmd_o.do_submit = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_REMOVE: begin
        cmd_o.do_remove = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_PEND: begin
        cmd_o.pend_load = 1'b1;
        idx_d           = '0;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.none_pending) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_step  = 1'b1;
          cmd_o.scan_first = (idx_q == '0);
          if (idx_q == SLOT_W'(MAX_TIMERS - 1)) begin
            state_d = ST_FIRE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_FIRE: begin
        cmd_o.fire = 1'b1;
        idx_d      = '0;
        state_d    = sts_i.fire_last ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/pts_datapath.sv =====
module pts_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts_pkg::pts_cmd_t cmd_i,
  output pts_pkg::pts_sts_t sts_o,
  input  logic [23:0]       interval_ms_i,
  input  logic [15:0]       repeat_count_i,
  input  logic [15:0]       task_id_i,
  output logic              result_valid_o,
  output logic [1:0]        event_kind_o,
  output logic [15:0]       timer_id_o,
  output logic              status_o,
  output logic              last_o
);
  import pts_pkg::*;

  logic [MAX_TIMERS-1:0] valid_q;
  logic [15:0]           id_q      [MAX_TIMERS];
  logic [23:0]           intv_q    [MAX_TIMERS];
  logic [31:0]           due_q     [MAX_TIMERS];
  logic [15:0]           rep_q     [MAX_TIMERS];
  logic [MAX_TIMERS-1:0] forever_q;

  logic [31:0]           time_q;
  logic [15:0]           next_id_q;
  logic [23:0]           intv_in_q;
  logic [15:0]           rep_in_q;
  logic [15:0]           task_in_q;

  logic [MAX_TIMERS-1:0] pending_q;
  logic                  found_q;
  logic [SLOT_W-1:0]     best_q;
  logic [31:0]           best_late_q;
  logic [FCNT_W-1:0]     fire_cnt_q;

  logic                  res_valid_q;
  logic [1:0]            res_kind_q;
  logic [15:0]           res_id_q;
  logic                  res_status_q;
  logic                  res_last_q;

  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic                  match_found;
  logic [SLOT_W-1:0]     match_idx;
  logic [MAX_TIMERS-1:0] pend_vec;
  logic [31:0]           late_cur;
  logic                  take_cur;
  logic [MAX_TIMERS-1:0] pend_rest;
  logic                  fire_last;
  logic [31:0]           due_next;
  logic                  fire_free;

  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
      if (valid_q[i] && (id_q[i] == task_in_q)) begin
        match_found = 1'b1;
        match_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_TIMERS; i++) begin
      pend_vec[i] = valid_q[i] && ((time_q - due_q[i]) < 32'h8000_0000);
    end
  end

  assign late_cur  = time_q - due_q[cmd_i.scan_idx];
  assign take_cur  = pending_q[cmd_i.scan_idx] &&
                     (cmd_i.scan_first || !found_q || (late_cur > best_late_q));
  assign pend_rest = pending_q & ~({{(MAX_TIMERS-1){1'b0}}, 1'b1} << best_q);
  assign fire_last = (pend_rest == '0) || (fire_cnt_q == FCNT_W'(RES_LIMIT - 1));
  assign due_next  = time_q + {8'b0, intv_q[best_q]};
  assign fire_free = !forever_q[best_q] && (rep_q[best_q] == '0);

  assign sts_o.none_pending = (pending_q == '0);
  assign sts_o.fire_last    = fire_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      time_q      <= '0;
      next_id_q   <= '0;
      pending_q   <= '0;
      found_q     <= 1'b0;
      fire_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.do_submit | cmd_i.do_remove | cmd_i.fire;
      if (cmd_i.time_inc) begin
        time_q <= time_q + 32'd1;
      end
      if (cmd_i.do_submit && free_found) begin
        valid_q[free_idx] <= 1'b1;
        next_id_q         <= next_id_q + 16'd1;
      end
      if (cmd_i.do_remove && match_found) begin
        valid_q[match_idx] <= 1'b0;
      end
      if (cmd_i.pend_load) begin
        pending_q  <= pend_vec;
        fire_cnt_q <= '0;
      end
      if (cmd_i.scan_step) begin
        found_q <= (!cmd_i.scan_first && found_q) || take_cur;
      end
      if (cmd_i.fire) begin
        pending_q[best_q] <= 1'b0;
        fire_cnt_q        <= fire_cnt_q + 1'b1;
        if (fire_free) begin
          valid_q[best_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      intv_in_q <= interval_ms_i;
      rep_in_q  <= repeat_count_i;
      task_in_q <= task_id_i;
    end
    if (cmd_i.do_submit && free_found) begin
      id_q[free_idx]      <= next_id_q;
      intv_q[free_idx]    <= intv_in_q;
      due_q[free_idx]     <= time_q;
      forever_q[free_idx] <= (rep_in_q == '0);
      rep_q[free_idx]     <= (rep_in_q == '0) ? '0 : rep_in_q - 16'd1;
    end
    if (cmd_i.scan_step && take_cur) begin
      best_q      <= cmd_i.scan_idx;
      best_late_q <= late_cur;
    end
    if (cmd_i.fire) begin
      if (forever_q[best_q]) begin
        due_q[best_q] <= due_next;
      end else if (rep_q[best_q] != '0) begin
        rep_q[best_q] <= rep_q[best_q] - 16'd1;
        due_q[best_q] <= due_next;
      end
    end
    if (cmd_i.do_submit) begin
      res_kind_q   <= EV_SUBMIT;
      res_id_q     <= free_found ? next_id_q : '0;
      res_status_q <= !free_found;
      res_last_q   <= 1'b1;
    end else if (cmd_i.do_remove) begin
      res_kind_q   <= EV_REMOVE;
      res_id_q     <= task_in_q;
      res_status_q <= !match_found;
      res_last_q   <= 1'b1;
    end else if (cmd_i.fire) begin
      res_kind_q   <= EV_FIRE;
      res_id_q     <= id_q[best_q];
      res_status_q <= 1'b0;
      res_last_q   <= fire_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign event_kind_o   = res_kind_q;
  assign timer_id_o     = res_id_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

endmodule

// ===== rtl/periodic_timer_scheduler.sv =====
// Submit and remove: one word out on result_valid_o, registered from the state after the accept.
// Tick: the accept edge bumps the clock, the PEND state flags due timers, then each fire
// takes a scan of all sixteen slots and a FIRE state, until none is due or the last fire.
// busy is high for the whole operation; one request is in flight at a time.
// Each result word is shown for one cycle only; the receiver cannot stall it.
// Reset (async, active low) empties the table and clears time and the id counter.
module periodic_timer_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [23:0] interval_ms_i,
  input  logic [15:0] repeat_count_i,
  input  logic [15:0] task_id_i,
  output logic        result_valid_o,
  output logic [1:0]  event_kind_o,
  output logic [15:0] timer_id_o,
  output logic        status_o,
  output logic        last_o
);
  import pts_pkg::*;

  pts_cmd_t cmd;
  pts_sts_t sts;

  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .busy       (busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pts_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .interval_ms_i  (interval_ms_i),
    .repeat_count_i (repeat_count_i),
    .task_id_i      (task_id_i),
    .result_valid_o (result_valid_o),
    .event_kind_o   (event_kind_o),
    .timer_id_o     (timer_id_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule
